// ----- rtl/core/assert_macros.svh -----
// shared assertion macros for the backoff controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define CBC_ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// same-cycle implication
`define CBC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/cbc_pkg.sv -----
`default_nettype none

package cbc_pkg;

  localparam int WIN_W   = 10;
  localparam int TIMER_W = 13;
  localparam int SLOTS_OUT_W = 11;

  // register indexes on the config port
  localparam logic [2:0] REG_SIFS   = 3'd0;
  localparam logic [2:0] REG_SLOT   = 3'd1;
  localparam logic [2:0] REG_ACK    = 3'd2;
  localparam logic [2:0] REG_CW_MIN = 3'd3;
  localparam logic [2:0] REG_CW_MAX = 3'd4;

  // reset values of the config registers
  localparam logic [9:0]  SIFS_RESET   = 10'd16;
  localparam logic [9:0]  SLOT_RESET   = 10'd9;
  localparam logic [11:0] ACK_RESET    = 12'd44;
  localparam logic [9:0]  CW_MIN_RESET = 10'd7;
  localparam logic [9:0]  CW_MAX_RESET = 10'd255;
  localparam logic [TIMER_W-1:0] WAIT_RESET =
    TIMER_W'(SIFS_RESET) + (TIMER_W'(SLOT_RESET) << 1);

  // event codes
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_REQUEST = 3'd1;
  localparam logic [2:0] ACT_IDLE    = 3'd2;
  localparam logic [2:0] ACT_BUSY    = 3'd3;
  localparam logic [2:0] ACT_COLLIDE = 3'd4;

  // codes reported on the result
  localparam logic [1:0] PHC_IDLE   = 2'd0;
  localparam logic [1:0] PHC_COUNT  = 2'd1;
  localparam logic [1:0] PHC_FROZEN = 2'd2;
  localparam logic [1:0] PHC_DONE   = 2'd3;
  localparam logic [1:0] TXC_NONE   = 2'd0;
  localparam logic [1:0] TXC_PEND   = 2'd1;
  localparam logic [1:0] TXC_SEND   = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_COUNT  = 4'b0010,
    PH_FROZEN = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    TX_NONE = 3'b001,
    TX_PEND = 3'b010,
    TX_SEND = 3'b100
  } tx_t;

  typedef enum logic [2:0] {
    CS_IDLE  = 3'b001,
    CS_BUSY  = 3'b010,
    CS_ERROR = 3'b100
  } cs_t;

  typedef struct packed {
    logic [9:0]  sifs_ticks;
    logic [9:0]  slot_ticks;
    logic [11:0] ack_ticks;
    logic [9:0]  cw_min;
    logic [9:0]  cw_max;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    tx_t                tx;
    cs_t                carrier;
    logic [WIN_W-1:0]   window;
    logic [TIMER_W-1:0] wait_timer;
  } core_state_t;

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] c;
    case (ph)
      PH_IDLE:   c = PHC_IDLE;
      PH_COUNT:  c = PHC_COUNT;
      PH_FROZEN: c = PHC_FROZEN;
      PH_DONE:   c = PHC_DONE;
      default:   c = PHC_IDLE;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] tx_code(input tx_t t);
    logic [1:0] c;
    case (t)
      TX_NONE: c = TXC_NONE;
      TX_PEND: c = TXC_PEND;
      TX_SEND: c = TXC_SEND;
      default: c = TXC_NONE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cbc_step.sv -----
`default_nettype none

// next-state and result logic for one event
module cbc_step #(
  parameter int SLOT_COUNT_BITS = 11,
  parameter int RANDOM_BITS = 16
) (
  input  cbc_pkg::cfg_t                cfg,
  input  cbc_pkg::core_state_t         cur,
  input  logic [SLOT_COUNT_BITS-1:0]   slot_count,
  input  logic [2:0]                   action,
  input  logic                         retry,
  input  logic [15:0]                  draw,
  output cbc_pkg::core_state_t         nxt,
  output logic [SLOT_COUNT_BITS-1:0]   slot_count_next,
  output logic                         expired,
  output logic                         rejected
);
  import cbc_pkg::*;

  localparam int DrawW = (RANDOM_BITS < 16) ? RANDOM_BITS : 16;
  localparam int ProdW = DrawW + WIN_W;
  localparam logic [SLOT_COUNT_BITS-1:0] SlotMax = {SLOT_COUNT_BITS{1'b1}};

  logic [TIMER_W-1:0] difs;
  logic [TIMER_W-1:0] eifs;
  logic [TIMER_W-1:0] timer_dec;
  logic [WIN_W:0]     grown;
  logic [WIN_W-1:0]   cw_max_eff;
  logic [WIN_W-1:0]   cw_min_eff;
  logic [WIN_W-1:0]   retry_window;
  logic [WIN_W-1:0]   draw_window;
  logic [ProdW-1:0]   prod;
  logic [ProdW:0]     drawn_plus;
  logic [SLOT_COUNT_BITS-1:0] drawn_slots;
  logic [SLOT_COUNT_BITS-1:0] slot_inc;
  logic [SLOT_COUNT_BITS-1:0] slot_dec;

  assign difs = TIMER_W'(cfg.sifs_ticks) + (TIMER_W'(cfg.slot_ticks) << 1);
  assign eifs = TIMER_W'(cfg.sifs_ticks) + TIMER_W'(cfg.slot_ticks)
              + TIMER_W'(cfg.ack_ticks);

  assign cw_max_eff = (cfg.cw_max == '0) ? WIN_W'(1) : cfg.cw_max;
  assign cw_min_eff = (cfg.cw_min == '0) ? WIN_W'(1) : cfg.cw_min;
  assign grown = {cur.window, 1'b1};
  assign retry_window = (grown < {1'b0, cw_max_eff}) ? grown[WIN_W-1:0] : cw_max_eff;

  // a retry draws against the grown window, a resume against the current one
  assign draw_window = (action == ACT_REQUEST) ? retry_window : cur.window;
  assign prod = ProdW'(draw[DrawW-1:0]) * ProdW'(draw_window);
  assign drawn_plus = (ProdW+1)'(prod >> RANDOM_BITS) + (ProdW+1)'(1);
  assign drawn_slots = (drawn_plus > (ProdW+1)'(SlotMax)) ? SlotMax
                     : drawn_plus[SLOT_COUNT_BITS-1:0];

  assign slot_inc = (slot_count == SlotMax) ? slot_count : slot_count + 1'b1;
  assign slot_dec = (slot_count == '0) ? slot_count : slot_count - 1'b1;
  assign timer_dec = (cur.wait_timer == '0) ? cur.wait_timer : cur.wait_timer - 1'b1;

  always_comb begin
    nxt = cur;
    slot_count_next = slot_count;
    expired = 1'b0;
    rejected = 1'b0;
    case (action)
      ACT_TICK: begin
        if (cur.phase == PH_COUNT) begin
          nxt.wait_timer = timer_dec;
          if (timer_dec == '0) begin
            slot_count_next = slot_dec;
            if (slot_dec == '0) begin
              if (cur.tx == TX_PEND) begin
                nxt.phase = PH_DONE;
                nxt.tx = TX_SEND;
                expired = 1'b1;
              end else begin
                nxt.phase = PH_IDLE;
              end
            end else begin
              nxt.wait_timer = TIMER_W'(cfg.slot_ticks);
            end
          end
        end
      end
      ACT_REQUEST: begin
        if (cur.tx != TX_NONE) begin
          rejected = 1'b1;
        end else if (cur.phase == PH_IDLE && cur.carrier == CS_IDLE) begin
          // medium free and nothing counting: go at once
          nxt.tx = TX_SEND;
          expired = 1'b1;
        end else if (retry) begin
          nxt.tx = TX_PEND;
          nxt.window = retry_window;
          slot_count_next = drawn_slots;
        end else begin
          nxt.tx = TX_PEND;
          nxt.window = cw_min_eff;
        end
      end
      ACT_IDLE: begin
        if (cur.carrier != CS_IDLE) begin
          nxt.carrier = CS_IDLE;
          nxt.phase = PH_COUNT;
          if (cur.tx == TX_SEND) begin
            nxt.tx = TX_NONE;
            slot_count_next = drawn_slots;
            nxt.wait_timer = difs;
          end else begin
            slot_count_next = slot_inc;
            nxt.wait_timer = (cur.carrier == CS_ERROR) ? eifs : difs;
          end
        end
      end
      ACT_BUSY, ACT_COLLIDE: begin
        nxt.carrier = (action == ACT_BUSY) ? CS_BUSY : CS_ERROR;
        if (cur.phase == PH_COUNT) begin
          nxt.wait_timer = '0;
          nxt.phase = PH_FROZEN;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/csma_ca_backoff_controller_unit.sv -----
`default_nettype none

// CSMA/CA backoff controller: takes one event beat per clock (tick, transmit
// request, carrier idle, carrier busy, collision) and returns exactly one result
// beat per event with the expiry flag and the carrier, backoff and transmit
// status. Sustained rate is one event per clock while out_stall is low; an
// event passes through the input register and then the result register. The
// longest path is the slot draw, a single 16 by 10 multiply from the input
// register to the state and result registers. After reset the registers hold
// their default timing (sifs 16, slot 9, ack 44, cw_min 7, cw_max 255) and a
// DIFS wait with one slot is running. Config writes take effect at once and
// are meant for idle periods only.
module csma_ca_backoff_controller_unit #(
  parameter int SLOT_COUNT_BITS = 11,
  parameter int RANDOM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  // event channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic        is_retransmission,
  input  logic [15:0] random_draw,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        backoff_expired,
  output logic        carrier_is_idle,
  output logic [1:0]  backoff_phase,
  output logic [1:0]  tx_phase,
  output logic [10:0] slots_left,
  output logic [9:0]  window_now,
  output logic        request_rejected
);
  import cbc_pkg::*;

  `include "assert_macros.svh"

  localparam int SlotExtW = (SLOT_COUNT_BITS > SLOTS_OUT_W) ? SLOT_COUNT_BITS : SLOTS_OUT_W;

  cfg_t cfg;

  // input register
  logic        s1_valid;
  logic [2:0]  s1_action;
  logic        s1_retry;
  logic [15:0] s1_draw;

  // controller state
  core_state_t state;
  core_state_t state_next;
  logic [SLOT_COUNT_BITS-1:0] slot_count;
  logic [SLOT_COUNT_BITS-1:0] slot_count_next;
  logic expired;
  logic rejected;
  logic [SlotExtW-1:0] slot_ext;

  logic in_beat;
  logic advance;

  // event leaves the input register when the result register is free or draining
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_beat  = in_valid && !in_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sifs_ticks <= SIFS_RESET;
      cfg.slot_ticks <= SLOT_RESET;
      cfg.ack_ticks  <= ACK_RESET;
      cfg.cw_min     <= CW_MIN_RESET;
      cfg.cw_max     <= CW_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIFS:   cfg.sifs_ticks <= cfg_data[9:0];
        REG_SLOT:   cfg.slot_ticks <= cfg_data[9:0];
        REG_ACK:    cfg.ack_ticks  <= cfg_data;
        REG_CW_MIN: cfg.cw_min     <= cfg_data[9:0];
        REG_CW_MAX: cfg.cw_max     <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_beat) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_action <= action;
      s1_retry  <= is_retransmission;
      s1_draw   <= random_draw;
    end
  end

  cbc_step #(
    .SLOT_COUNT_BITS(SLOT_COUNT_BITS),
    .RANDOM_BITS(RANDOM_BITS)
  ) u_step (
    .cfg             (cfg),
    .cur             (state),
    .slot_count      (slot_count),
    .action          (s1_action),
    .retry           (s1_retry),
    .draw            (s1_draw),
    .nxt             (state_next),
    .slot_count_next (slot_count_next),
    .expired         (expired),
    .rejected        (rejected)
  );

  // state commits together with the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= PH_COUNT;
      state.tx         <= TX_NONE;
      state.carrier    <= CS_IDLE;
      state.window     <= CW_MIN_RESET;
      state.wait_timer <= WAIT_RESET;
      slot_count       <= SLOT_COUNT_BITS'(1);
    end else if (advance) begin
      state      <= state_next;
      slot_count <= slot_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign slot_ext = SlotExtW'(slot_count_next);

  always_ff @(posedge clk) begin
    if (advance) begin
      backoff_expired  <= expired;
      carrier_is_idle  <= (state_next.carrier == CS_IDLE);
      backoff_phase    <= phase_code(state_next.phase);
      tx_phase         <= tx_code(state_next.tx);
      // saturate the reported count to the output width
      slots_left       <= (slot_ext > SlotExtW'(11'h7FF)) ? 11'h7FF : slot_ext[10:0];
      window_now       <= state_next.window;
      request_rejected <= rejected;
    end
  end

  // an expiry beat always reports the transmission as started
  `CBC_ASSERT_IMPLIES(a_expired_sends, clk, rst, out_valid && backoff_expired, tx_phase == TXC_SEND)
  // counting down never runs with an empty slot count
  `CBC_ASSERT_IMPLIES(a_count_has_slots, clk, rst, state.phase == PH_COUNT, slot_count != '0)
  // the window is never zero
  `CBC_ASSERT_ALWAYS(a_window_nonzero, clk, rst, state.window != '0)
  // every event leaving the input register shows up as a result beat
  `CBC_ASSERT_NEXT(a_advance_result, clk, rst, advance, out_valid)

endmodule

`default_nettype wire

// ----- tb/backoff_checker.sv -----
module backoff_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  action,
  input  logic        is_retransmission,
  input  logic [15:0] random_draw,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        backoff_expired,
  input  logic        carrier_is_idle,
  input  logic [1:0]  backoff_phase,
  input  logic [1:0]  tx_phase,
  input  logic [10:0] slots_left,
  input  logic [9:0]  window_now,
  input  logic        request_rejected,
  output int          mismatches,
  output int          pending
);
  import cbc_pkg::*;

  typedef struct packed {
    logic        expired;
    logic        idle;
    logic [1:0]  phase;
    logic [1:0]  tx;
    logic [10:0] slots;
    logic [9:0]  window;
    logic        rejected;
  } mac_status_t;

  // timing and window registers as the block holds them
  logic [9:0]  sifs_len, slot_len, cw_floor, cw_ceiling;
  logic [11:0] ack_len;

  // backoff state
  logic [1:0]        ph, txs;
  cs_t               carrier;
  logic [WIN_W-1:0]  win;
  logic [10:0]       slots;
  logic [TIMER_W-1:0] timer;

  mac_status_t status_due[$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic logic [TIMER_W-1:0] difs_ticks();
    return TIMER_W'(sifs_len) + (TIMER_W'(slot_len) << 1);
  endfunction

  function automatic logic [TIMER_W-1:0] eifs_ticks();
    return TIMER_W'(sifs_len) + TIMER_W'(slot_len) + TIMER_W'(ack_len);
  endfunction

  // floor(draw * window / 2^16) + 1
  function automatic logic [10:0] drawn_slots(input logic [15:0] draw);
    logic [25:0] prod;
    prod = draw * win;
    return {1'b0, prod[25:16]} + 11'd1;
  endfunction

  task automatic advance_backoff(input logic [2:0] act, input logic retry,
                                 input logic [15:0] draw, output mac_status_t st);
    logic [10:0] grown;
    logic [9:0]  lim;
    logic        was_error;
    st = '0;
    case (act)
      ACT_TICK: begin
        if (ph == PHC_COUNT) begin
          if (timer != 0) timer = timer - 1'b1;
          if (timer == 0) begin
            if (slots != 0) slots = slots - 1'b1;
            if (slots == 0) begin
              if (txs == TXC_PEND) begin
                ph = PHC_DONE;
                txs = TXC_SEND;
                st.expired = 1'b1;
              end else begin
                ph = PHC_IDLE;
              end
            end else begin
              timer = TIMER_W'(slot_len);
            end
          end
        end
      end
      ACT_REQUEST: begin
        if (txs != TXC_NONE) begin
          st.rejected = 1'b1;
        end else if (ph == PHC_IDLE && carrier == CS_IDLE) begin
          // medium free and nothing counting: go at once
          txs = TXC_SEND;
          st.expired = 1'b1;
        end else begin
          txs = TXC_PEND;
          if (retry) begin
            lim = (cw_ceiling == 0) ? 10'd1 : cw_ceiling;
            grown = {win, 1'b1};
            win = (grown < {1'b0, lim}) ? grown[9:0] : lim;
            slots = drawn_slots(draw);
          end else begin
            win = (cw_floor == 0) ? 10'd1 : cw_floor;
          end
        end
      end
      ACT_IDLE: begin
        if (carrier != CS_IDLE) begin
          was_error = (carrier == CS_ERROR);
          carrier = CS_IDLE;
          if (txs == TXC_SEND) begin
            txs = TXC_NONE;
            slots = drawn_slots(draw);
            timer = difs_ticks();
          end else begin
            if (slots != 11'h7FF) slots = slots + 1'b1;
            timer = was_error ? eifs_ticks() : difs_ticks();
          end
          ph = PHC_COUNT;
        end
      end
      ACT_BUSY, ACT_COLLIDE: begin
        carrier = (act == ACT_BUSY) ? CS_BUSY : CS_ERROR;
        if (ph == PHC_COUNT) begin
          timer = '0;
          ph = PHC_FROZEN;
        end
      end
      default: ;
    endcase
    st.idle = (carrier == CS_IDLE);
    st.phase = ph;
    st.tx = txs;
    st.slots = slots;
    st.window = win;
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    mac_status_t want, next_status;
    if (rst) begin
      sifs_len = SIFS_RESET;
      slot_len = SLOT_RESET;
      ack_len = ACK_RESET;
      cw_floor = CW_MIN_RESET;
      cw_ceiling = CW_MAX_RESET;
      ph = PHC_COUNT;
      txs = TXC_NONE;
      carrier = CS_IDLE;
      win = CW_MIN_RESET;
      slots = 11'd1;
      timer = WAIT_RESET;
      status_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing expected", $time);
        end else begin
          want = status_due.pop_front();
          check_field("backoff_expired", want.expired, backoff_expired);
          check_field("carrier_is_idle", want.idle, carrier_is_idle);
          check_field("backoff_phase", want.phase, backoff_phase);
          check_field("tx_phase", want.tx, tx_phase);
          check_field("slots_left", want.slots, slots_left);
          check_field("window_now", want.window, window_now);
          check_field("request_rejected", want.rejected, request_rejected);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SIFS:   sifs_len = cfg_data[9:0];
          REG_SLOT:   slot_len = cfg_data[9:0];
          REG_ACK:    ack_len = cfg_data;
          REG_CW_MIN: cw_floor = cfg_data[9:0];
          REG_CW_MAX: cw_ceiling = cfg_data[9:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_backoff(action, is_retransmission, random_draw, next_status);
        status_due.push_back(next_status);
      end
    end
    pending = status_due.size();
  end

endmodule

// ----- tb/tb.sv -----
module tb;
  import cbc_pkg::*;

  // codes past collision, which the block must ignore
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  // percent of cycles in which either side holds off
  localparam int IDLE_PCT = 19;
  // cycles without any accepted beat before the run is declared hung
  localparam int QUIET_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  action;
  logic        is_retransmission;
  logic [15:0] random_draw;
  logic        out_valid;
  logic        out_stall;
  logic        backoff_expired;
  logic        carrier_is_idle;
  logic [1:0]  backoff_phase;
  logic [1:0]  tx_phase;
  logic [10:0] slots_left;
  logic [9:0]  window_now;
  logic        request_rejected;

  int mismatches;
  int pending;

  // no idling on either side while this is set
  bit calm;
  int quiet_cycles;
  int tick_count, request_count, carrier_count, spare_count, setting_count;

  csma_ca_backoff_controller_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .is_retransmission(is_retransmission),
    .random_draw(random_draw),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .backoff_expired(backoff_expired),
    .carrier_is_idle(carrier_is_idle),
    .backoff_phase(backoff_phase),
    .tx_phase(tx_phase),
    .slots_left(slots_left),
    .window_now(window_now),
    .request_rejected(request_rejected)
  );

  backoff_checker u_checker (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .is_retransmission(is_retransmission),
    .random_draw(random_draw),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .backoff_expired(backoff_expired),
    .carrier_is_idle(carrier_is_idle),
    .backoff_phase(backoff_phase),
    .tx_phase(tx_phase),
    .slots_left(slots_left),
    .window_now(window_now),
    .request_rejected(request_rejected),
    .mismatches(mismatches),
    .pending(pending)
  );

  always #6 clk = ~clk;

  // result side back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // watchdog: any accepted beat on either channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog, no beat accepted for %0d cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one register write per falling edge; the caller drops the enable
  task automatic write_reg(input logic [2:0] idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 12'(value);
    @(negedge clk);
  endtask

  task automatic apply_setting(input int sifs, input int slot, input int ack,
                               input int cwmin, input int cwmax);
    write_reg(REG_SIFS, sifs);
    write_reg(REG_SLOT, slot);
    write_reg(REG_ACK, ack);
    write_reg(REG_CW_MIN, cwmin);
    write_reg(REG_CW_MAX, cwmax);
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  // one event beat; returns on the falling edge after it was taken
  task automatic send_event(input logic [2:0] act, input logic retry,
                            input logic [15:0] draw);
    // random hold-off before the beat
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    is_retransmission <= retry;
    random_draw <= draw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (act)
      ACT_TICK:    tick_count++;
      ACT_REQUEST: request_count++;
      ACT_IDLE, ACT_BUSY, ACT_COLLIDE: carrier_count++;
      default:     spare_count++;
    endcase
    @(negedge clk);
  endtask

  // event with random retry flag and draw
  task automatic send_any(input logic [2:0] act);
    send_event(act, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
  endtask

  task automatic tick_burst(input int n);
    repeat (n) send_any(ACT_TICK);
  endtask

  // stop sending and wait until every result beat is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // mostly well-formed traffic: requests followed by ticks, frames on the air
  // that end with carrier idle, plus stray events and unused codes
  task automatic run_random(input int count);
    int made;
    int pick;
    int n;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        n = $urandom_range(1, 24);
        tick_burst(n);
        made += n;
      end else if (pick < 55) begin
        n = $urandom_range(0, 16);
        send_any(ACT_REQUEST);
        tick_burst(n);
        made += n + 1;
      end else if (pick < 72) begin
        // busy or collision, a few ticks, then the medium clears
        n = $urandom_range(0, 3);
        send_any($urandom_range(0, 1) ? ACT_BUSY : ACT_COLLIDE);
        tick_burst(n);
        send_any(ACT_IDLE);
        made += n + 2;
      end else if (pick < 80) begin
        send_any(ACT_IDLE);
        made++;
      end else if (pick < 88) begin
        send_any($urandom_range(0, 1) ? ACT_BUSY : ACT_COLLIDE);
        made++;
      end else if (pick < 93) begin
        // ignored codes, not counted
        send_any(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)));
      end else if (pick < 98) begin
        send_any(ACT_REQUEST);
        made++;
      end else begin
        // sender holds off until every result is back
        drain_results();
      end
    end
  endtask

  task automatic run_setting(input int sifs, input int slot, input int ack,
                             input int cwmin, input int cwmax, input int count);
    drain_results();
    apply_setting(sifs, slot, ack, cwmin, cwmax);
    run_random(count);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_SIFS;
    cfg_data = '0;
    in_valid = 1'b0;
    action = ACT_TICK;
    is_retransmission = 1'b0;
    random_draw = '0;
    out_stall = 1'b0;
    calm = 1'b0;
    quiet_cycles = 0;
    tick_count = 0;
    request_count = 0;
    carrier_count = 0;
    spare_count = 0;
    setting_count = 0;

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed: shortest timing and windows so every path is reached quickly
    apply_setting(1, 1, 0, 1, 1);
    send_event(ACT_SPARE_LO, 1'b1, 16'hFFFF);
    send_event(ACT_SPARE_HI, 1'b0, 16'h0000);
    send_any(ACT_IDLE);                       // idle while already idle
    send_any(ACT_BUSY);                       // freezes the reset countdown
    send_any(ACT_BUSY);                       // busy while frozen
    send_any(ACT_COLLIDE);
    send_any(ACT_IDLE);                       // resume after eifs, one slot added
    tick_burst(3);                            // count runs out, nothing pending
    send_event(ACT_REQUEST, 1'b0, 16'h0000);  // straight to transmit
    send_event(ACT_REQUEST, 1'b1, 16'hFFFF);  // outstanding, rejected
    send_any(ACT_BUSY);
    send_event(ACT_IDLE, 1'b0, 16'hFFFF);     // end of frame, top draw
    send_event(ACT_REQUEST, 1'b1, 16'h0000);  // retry, window pinned at cw_max
    send_any(ACT_COLLIDE);
    send_any(ACT_IDLE);
    tick_burst(4);                            // expiry with request pending
    send_any(ACT_BUSY);
    send_any(ACT_IDLE);
    send_event(ACT_REQUEST, 1'b0, 16'hFFFF);  // first try resets the window

    // random phases over several register settings
    run_setting(SIFS_RESET, SLOT_RESET, ACK_RESET, CW_MIN_RESET, CW_MAX_RESET, 250);
    run_setting(1, 1, 0, 1, 1, 200);
    calm = 1'b1;                              // long stretch with no idling
    run_setting(3, 2, 5, 3, 31, 250);
    calm = 1'b0;
    run_setting(1023, 1023, 4095, 1023, 1023, 60);
    run_setting($urandom_range(1, 6), $urandom_range(1, 3), $urandom_range(0, 12),
                $urandom_range(1, 31), $urandom_range(1, 1023), 200);
    run_setting(2, 1, 7, 1, 1023, 240);

    drain_results();
    repeat (8) @(negedge clk);

    $display("covered %0d beats: %0d ticks, %0d requests, %0d carrier events, %0d unused codes",
             tick_count + request_count + carrier_count + spare_count,
             tick_count, request_count, carrier_count, spare_count);
    $display("over %0d register settings, with and without idling on both channels",
             setting_count);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
